// ===== src/bclp_pkg.sv =====
// ----------------------------------------------------------------------------
// bclp_pkg: shared definitions for the button click / long-press detector
// Operation codes, register indexes, event bit positions, phase encodings
// and the structures passed between the configuration, step and top modules.
// ----------------------------------------------------------------------------
package bclp_pkg;

   // Widths fixed by the interface.
   localparam int EVENT_BITS       = 13;
   localparam int NOW_BITS         = 32;
   localparam int THRESHOLD_BITS   = 16;
   localparam int CSR_INDEX_BITS   = 3;
   localparam int CSR_DATA_BITS    = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   // Operation codes carried by each input beat.
   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_CLEAR_MASK = 2'd1;
   localparam logic [1:0] OP_CLEAR_ALL  = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWAP_UP_DOWN     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUICK_RELEASE    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SECOND_PRESS     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLICK_LONG       = 3'd4;

   // Register values after reset.
   localparam logic [THRESHOLD_BITS-1:0] LONG_PRESS_RESET    = 16'd500;
   localparam logic [THRESHOLD_BITS-1:0] QUICK_RELEASE_RESET = 16'd200;
   localparam logic [THRESHOLD_BITS-1:0] SECOND_PRESS_RESET  = 16'd300;
   localparam logic [THRESHOLD_BITS-1:0] CLICK_LONG_RESET    = 16'd1500;

   // Event flag bit positions.
   localparam int EV_ONOFF_CLICK      = 0;
   localparam int EV_ONOFF_LONG       = 1;
   localparam int EV_ONOFF_CLICK_LONG = 2;
   localparam int EV_M_CLICK          = 3;
   localparam int EV_M_LONG           = 4;
   localparam int EV_UP_CLICK         = 5;
   localparam int EV_UP_LONG          = 6;
   localparam int EV_DOWN_CLICK       = 7;
   localparam int EV_DOWN_LONG        = 8;
   localparam int EV_UPDOWN_LONG      = 9;
   localparam int EV_ONOFF_UP_LONG    = 10;
   localparam int EV_ONOFF_DOWN_LONG  = 11;
   localparam int EV_ALL_THREE_LONG   = 12;

   // Press start time slots.
   localparam int IDX_ONOFF = 0;
   localparam int IDX_M     = 1;
   localparam int IDX_UP    = 2;
   localparam int IDX_DOWN  = 3;
   localparam int BUTTONS   = 4;

   // The on/off machine also tracks a click followed by a long hold.
   typedef enum logic [2:0] {
      OO_IDLE         = 3'd0,
      OO_HELD         = 3'd1,
      OO_WAIT_RELEASE = 3'd2,
      OO_WAIT_SECOND  = 3'd3,
      OO_SECOND_HOLD  = 3'd4
   } onoff_phase_type;

   typedef enum logic [1:0] {
      BP_IDLE         = 2'd0,
      BP_HELD         = 2'd1,
      BP_WAIT_RELEASE = 2'd2
   } btn_phase_type;

   typedef struct packed {
      logic                      swap_up_down;
      logic [THRESHOLD_BITS-1:0] long_press_ms;
      logic [THRESHOLD_BITS-1:0] quick_release_ms;
      logic [THRESHOLD_BITS-1:0] second_press_wait_ms;
      logic [THRESHOLD_BITS-1:0] click_long_ms;
   } cfg_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic                  up_level;
      logic                  down_level;
      logic                  onoff_level;
      logic                  m_level;
      logic [NOW_BITS-1:0]   now_ms;
      logic [EVENT_BITS-1:0] clear_mask;
   } item_type;

   typedef struct packed {
      onoff_phase_type       onoff_phase;
      btn_phase_type         m_phase;
      btn_phase_type         up_phase;
      btn_phase_type         down_phase;
      logic                  hold_after_clear;
      logic [EVENT_BITS-1:0] event_flags;
   } state_type;

endpackage

// ===== src/button_click_long_press_detector.sv =====
// An accepted beat is held in the input register, and its result is registered in the result register.
// Throughput: one beat per clock cycle unless the receiver stalls, set by the single step
// between the input register and the result register, which also updates the press state.
// Reset (synchronous, active high) empties both registers, puts every press
// machine to idle, clears all event flags and restores the register defaults.
// ----------------------------------------------------------------------------
// button_click_long_press_detector: top level
// Input register, press-machine step and result register with the handshake,
// plus the configuration registers and the persistent press state.
// ----------------------------------------------------------------------------
module button_click_long_press_detector
   import bclp_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_operation,
   input  logic                      req_up_level,
   input  logic                      req_down_level,
   input  logic                      req_onoff_level,
   input  logic                      req_m_level,
   input  logic [NOW_BITS-1:0]       req_now_ms,
   input  logic [EVENT_BITS-1:0]     req_clear_mask,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [EVENT_BITS-1:0]     rsp_pending_events,

   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type                           cfg;
   item_type                          item_ff;
   logic                              in_valid_ff;
   logic                              out_valid_ff;
   logic [EVENT_BITS-1:0]             events_ff;
   state_type                         state_ff;
   state_type                         state_in;
   logic [BUTTONS-1:0][TIME_BITS-1:0] start_ff;
   logic [BUTTONS-1:0][TIME_BITS-1:0] start_in;
   logic                              advance;
   logic                              req_accept;

   bclp_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   bclp_step #(
      .TIME_BITS (TIME_BITS)
   ) u_step (
      .cfg       (cfg),
      .item      (item_ff),
      .state_cur (state_ff),
      .start_cur (start_ff),
      .state_nxt (state_in),
      .start_nxt (start_in)
   );

   // A beat moves on when the result register is empty or being taken.
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.operation   <= req_operation;
         item_ff.up_level    <= req_up_level;
         item_ff.down_level  <= req_down_level;
         item_ff.onoff_level <= req_onoff_level;
         item_ff.m_level     <= req_m_level;
         item_ff.now_ms      <= req_now_ms;
         item_ff.clear_mask  <= req_clear_mask;
      end
   end

   // Press state commits together with the result of the same beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.onoff_phase      <= OO_IDLE;
         state_ff.m_phase          <= BP_IDLE;
         state_ff.up_phase         <= BP_IDLE;
         state_ff.down_phase       <= BP_IDLE;
         state_ff.hold_after_clear <= 1'b0;
         state_ff.event_flags      <= '0;
         start_ff                  <= '0;
      end else if (advance) begin
         state_ff <= state_in;
         start_ff <= start_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         events_ff <= state_in.event_flags;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pending_events = events_ff;

   // A stalled input means both registers are full and the output is held.
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled while the result register could take a beat");

   // A beat that moves on is presented at the output on the next cycle.
   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced beat did not reach the result register");

   // The presented result always matches the committed flags.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pending_events == state_ff.event_flags))
      else $error("result differs from the latched event flags");

   // A clear-all leaves no flag set and arms the hold.
   a_clear_all_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.operation == OP_CLEAR_ALL)
      |=> (rsp_pending_events == '0 && state_ff.hold_after_clear))
      else $error("clear-all left flags set or hold not armed");

endmodule

// ===== src/bclp_csr.sv =====
// ----------------------------------------------------------------------------
// bclp_csr: configuration registers
// Holds the swap control and the four millisecond thresholds, written one
// register per enabled clock edge. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bclp_csr
   import bclp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SWAP_UP_DOWN: cfg_in.swap_up_down         = csr_write_data[0];
            CSR_LONG_PRESS:   cfg_in.long_press_ms        = csr_write_data;
            CSR_QUICK_RELEASE: cfg_in.quick_release_ms    = csr_write_data;
            CSR_SECOND_PRESS: cfg_in.second_press_wait_ms = csr_write_data;
            CSR_CLICK_LONG:   cfg_in.click_long_ms        = csr_write_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   // Register bank with its reset defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swap_up_down         <= 1'b0;
         cfg_ff.long_press_ms        <= LONG_PRESS_RESET;
         cfg_ff.quick_release_ms     <= QUICK_RELEASE_RESET;
         cfg_ff.second_press_wait_ms <= SECOND_PRESS_RESET;
         cfg_ff.click_long_ms        <= CLICK_LONG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/bclp_step.sv =====
// ----------------------------------------------------------------------------
// bclp_step: next-state logic for one beat
// Runs the on/off, M, up and down press machines in that order on a sample
// tick, or applies a masked or full clear, and gives the new state.
// ----------------------------------------------------------------------------
module bclp_step
   import bclp_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
   input  cfg_type                             cfg,
   input  item_type                            item,
   input  state_type                           state_cur,
   input  logic [BUTTONS-1:0][TIME_BITS-1:0]   start_cur,
   output state_type                           state_nxt,
   output logic [BUTTONS-1:0][TIME_BITS-1:0]   start_nxt
);

   // Clear-all: drop every flag and phase and wait for all buttons released.
   function automatic state_type clear_all_state(input state_type s);
      state_type r;
      r                  = s;
      r.hold_after_clear = 1'b1;
      r.event_flags      = '0;
      r.onoff_phase      = OO_IDLE;
      r.m_phase          = BP_IDLE;
      r.up_phase         = BP_IDLE;
      r.down_phase       = BP_IDLE;
      return r;
   endfunction

   logic [TIME_BITS+NOW_BITS-1:0] now_wide;
   logic [TIME_BITS-1:0]          now_t;
   logic                          up;
   logic                          down;
   logic                          onoff;
   logic                          m;
   logic                          any_held;
   logic [TIME_BITS-1:0]          el_onoff;
   logic [TIME_BITS-1:0]          el_m;
   logic [TIME_BITS-1:0]          el_up;
   logic [TIME_BITS-1:0]          el_down;
   logic                          onoff_long;
   logic                          onoff_quick;
   logic                          onoff_wait_over;
   logic                          onoff_click_long;
   logic                          m_long;
   logic                          up_long;
   logic                          down_long;

   // Time is taken modulo the stored width; elapsed time wraps the same way.
   assign now_wide = {{TIME_BITS{1'b0}}, item.now_ms};
   assign now_t    = now_wide[TIME_BITS-1:0];
   assign el_onoff = now_t - start_cur[IDX_ONOFF];
   assign el_m     = now_t - start_cur[IDX_M];
   assign el_up    = now_t - start_cur[IDX_UP];
   assign el_down  = now_t - start_cur[IDX_DOWN];

   assign onoff_long       = el_onoff >  TIME_BITS'(cfg.long_press_ms);
   assign onoff_quick      = el_onoff <= TIME_BITS'(cfg.quick_release_ms);
   assign onoff_wait_over  = el_onoff >  TIME_BITS'(cfg.second_press_wait_ms);
   assign onoff_click_long = el_onoff >  TIME_BITS'(cfg.click_long_ms);
   assign m_long           = el_m     >  TIME_BITS'(cfg.long_press_ms);
   assign up_long          = el_up    >  TIME_BITS'(cfg.long_press_ms);
   assign down_long        = el_down  >  TIME_BITS'(cfg.long_press_ms);

   // Button levels, with up and down exchanged when configured.
   assign up       = cfg.swap_up_down ? item.down_level : item.up_level;
   assign down     = cfg.swap_up_down ? item.up_level : item.down_level;
   assign onoff    = item.onoff_level;
   assign m        = item.m_level;
   assign any_held = up | down | onoff | m;

   // Machines update in sequence; each sees what the earlier ones wrote.
   always_comb begin
      state_nxt = state_cur;
      start_nxt = start_cur;
      unique case (item.operation)
         OP_TICK: begin
            if (!(state_cur.hold_after_clear && any_held)) begin
               state_nxt.hold_after_clear = 1'b0;

               // On/off button.
               unique case (state_nxt.onoff_phase)
                  OO_IDLE: begin
                     if (onoff) begin
                        start_nxt[IDX_ONOFF]  = now_t;
                        state_nxt.onoff_phase = OO_HELD;
                     end
                  end
                  OO_HELD: begin
                     if (onoff_long) begin
                        state_nxt.event_flags[EV_ONOFF_LONG] = 1'b1;
                        state_nxt.onoff_phase = OO_WAIT_RELEASE;
                     end else if (!onoff) begin
                        if (onoff_quick) begin
                           start_nxt[IDX_ONOFF]  = now_t;
                           state_nxt.onoff_phase = OO_WAIT_SECOND;
                        end else begin
                           state_nxt.event_flags[EV_ONOFF_CLICK] = 1'b1;
                           state_nxt.onoff_phase = OO_IDLE;
                        end
                     end
                  end
                  OO_WAIT_RELEASE: begin
                     if (!onoff) begin
                        state_nxt.onoff_phase = OO_IDLE;
                     end
                  end
                  OO_WAIT_SECOND: begin
                     if (onoff) begin
                        start_nxt[IDX_ONOFF]  = now_t;
                        state_nxt.onoff_phase = OO_SECOND_HOLD;
                     end else if (onoff_wait_over) begin
                        state_nxt.event_flags[EV_ONOFF_CLICK] = 1'b1;
                        state_nxt.onoff_phase = OO_IDLE;
                     end
                  end
                  OO_SECOND_HOLD: begin
                     if (onoff_click_long) begin
                        state_nxt.event_flags[EV_ONOFF_CLICK_LONG] = 1'b1;
                        state_nxt.onoff_phase = OO_WAIT_RELEASE;
                     end else if (!onoff) begin
                        state_nxt.event_flags[EV_ONOFF_CLICK] = 1'b1;
                        state_nxt.onoff_phase = OO_IDLE;
                     end
                  end
                  default: begin
                     state_nxt.onoff_phase = OO_IDLE;
                  end
               endcase

               // M button.
               unique case (state_nxt.m_phase)
                  BP_IDLE: begin
                     if (m) begin
                        start_nxt[IDX_M]  = now_t;
                        state_nxt.m_phase = BP_HELD;
                     end
                  end
                  BP_HELD: begin
                     if (m_long) begin
                        state_nxt.event_flags[EV_M_LONG] = 1'b1;
                        state_nxt.m_phase = BP_WAIT_RELEASE;
                     end else if (!m) begin
                        state_nxt.event_flags[EV_M_CLICK] = 1'b1;
                        state_nxt.m_phase = BP_IDLE;
                     end
                  end
                  BP_WAIT_RELEASE: begin
                     if (!m) begin
                        state_nxt.m_phase = BP_IDLE;
                     end
                  end
                  default: begin
                     state_nxt.m_phase = BP_IDLE;
                  end
               endcase

               // Up button, with its chords.
               unique case (state_nxt.up_phase)
                  BP_IDLE: begin
                     if (up) begin
                        start_nxt[IDX_UP]  = now_t;
                        state_nxt.up_phase = BP_HELD;
                     end
                  end
                  BP_HELD: begin
                     if (up_long) begin
                        if (onoff && down) begin
                           state_nxt = clear_all_state(state_nxt);
                           state_nxt.event_flags[EV_ALL_THREE_LONG] = 1'b1;
                        end else if (onoff) begin
                           state_nxt.event_flags[EV_ONOFF_UP_LONG] = 1'b1;
                        end else if (down) begin
                           state_nxt.event_flags[EV_UPDOWN_LONG] = 1'b1;
                        end else begin
                           state_nxt.event_flags[EV_UP_LONG] = 1'b1;
                        end
                        state_nxt.up_phase = BP_WAIT_RELEASE;
                     end else if (!up) begin
                        state_nxt.event_flags[EV_UP_CLICK] = 1'b1;
                        state_nxt.up_phase = BP_IDLE;
                     end
                  end
                  BP_WAIT_RELEASE: begin
                     if (!up) begin
                        state_nxt.up_phase = BP_IDLE;
                     end
                  end
                  default: begin
                     state_nxt.up_phase = BP_IDLE;
                  end
               endcase

               // Down button, with its chords.
               unique case (state_nxt.down_phase)
                  BP_IDLE: begin
                     if (down) begin
                        start_nxt[IDX_DOWN]  = now_t;
                        state_nxt.down_phase = BP_HELD;
                     end
                  end
                  BP_HELD: begin
                     if (down_long) begin
                        if (onoff && up) begin
                           state_nxt = clear_all_state(state_nxt);
                           state_nxt.event_flags[EV_ALL_THREE_LONG] = 1'b1;
                        end else if (onoff) begin
                           state_nxt.event_flags[EV_ONOFF_DOWN_LONG] = 1'b1;
                        end else if (up) begin
                           state_nxt.event_flags[EV_UPDOWN_LONG] = 1'b1;
                        end else begin
                           state_nxt.event_flags[EV_DOWN_LONG] = 1'b1;
                        end
                        state_nxt.down_phase = BP_WAIT_RELEASE;
                     end else if (!down) begin
                        state_nxt.event_flags[EV_DOWN_CLICK] = 1'b1;
                        state_nxt.down_phase = BP_IDLE;
                     end
                  end
                  BP_WAIT_RELEASE: begin
                     if (!down) begin
                        state_nxt.down_phase = BP_IDLE;
                     end
                  end
                  default: begin
                     state_nxt.down_phase = BP_IDLE;
                  end
               endcase
            end
         end
         OP_CLEAR_MASK: begin
            state_nxt.event_flags = state_cur.event_flags & ~item.clear_mask;
         end
         OP_CLEAR_ALL: begin
            state_nxt = clear_all_state(state_cur);
         end
         default: begin
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

// ===== dv/button_click_long_press_detector_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_long_press_detector_tb: self-checking bench for the detector
// Drives sample ticks, masked clears and clear-alls through the valid/stall
// request channel and predicts the sticky event flags beat by beat. Presses
// are built as click, long, click-then-long, chord and noise sequences around
// the configured thresholds, under several register settings, with random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module button_click_long_press_detector_tb;
   import bclp_pkg::*;

   // Operation code the block must treat as a no-op.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Button level vectors, ordered {on/off, M, up, down}.
   localparam logic [3:0] B_NONE  = 4'b0000;
   localparam logic [3:0] B_ONOFF = 4'b1000;
   localparam logic [3:0] B_M     = 4'b0100;
   localparam logic [3:0] B_UP    = 4'b0010;
   localparam logic [3:0] B_DOWN  = 4'b0001;

   localparam int LONG_HOLD_CYCLES = 300;

   typedef enum {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_type;
   typedef enum {G_CLICK, G_LONG, G_CLICK_LONG, G_CHORD, G_NOISE, G_CLEAR_ALL,
                 G_JUMP} gesture_kind_type;

   // Scoreboard: keeps its own copy of the press machines and flags, and
   // queues the flag word expected for every accepted request beat.
   class event_scoreboard;
      cfg_type                cfg;
      onoff_phase_type        oo_ph;
      btn_phase_type          m_ph;
      btn_phase_type          up_ph;
      btn_phase_type          dn_ph;
      logic [NOW_BITS-1:0]    started [BUTTONS];
      logic                   held_after_clear;
      logic [EVENT_BITS-1:0]  flags;
      logic [EVENT_BITS-1:0]  expected_events [$];
      int unsigned            errors;

      function new();
         cfg.swap_up_down         = 1'b0;
         cfg.long_press_ms        = LONG_PRESS_RESET;
         cfg.quick_release_ms     = QUICK_RELEASE_RESET;
         cfg.second_press_wait_ms = SECOND_PRESS_RESET;
         cfg.click_long_ms        = CLICK_LONG_RESET;
         oo_ph = OO_IDLE;
         m_ph  = BP_IDLE;
         up_ph = BP_IDLE;
         dn_ph = BP_IDLE;
         foreach (started[i]) started[i] = '0;
         held_after_clear = 1'b0;
         flags  = '0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            CSR_SWAP_UP_DOWN:  cfg.swap_up_down         = val[0];
            CSR_LONG_PRESS:    cfg.long_press_ms        = val;
            CSR_QUICK_RELEASE: cfg.quick_release_ms     = val;
            CSR_SECOND_PRESS:  cfg.second_press_wait_ms = val;
            CSR_CLICK_LONG:    cfg.click_long_ms        = val;
            default: ;
         endcase
      endfunction

      function void report(string msg);
         errors++;
         $display("%0t ns: mismatch: %s", $time, msg);
      endfunction

      // Elapsed time since a press started, wrapping modulo 2^32.
      function logic [NOW_BITS-1:0] age(logic [NOW_BITS-1:0] now, int idx);
         return now - started[idx];
      endfunction

      function void clear_everything();
         held_after_clear = 1'b1;
         flags = '0;
         oo_ph = OO_IDLE;
         m_ph  = BP_IDLE;
         up_ph = BP_IDLE;
         dn_ph = BP_IDLE;
      endfunction

      // Shared machine for M, up and down. M passes no chord partners, so
      // only its own long bit can be reached.
      function btn_phase_type step_side(btn_phase_type ph, logic lv, logic other,
                                        logic oo_lv, int idx, int click_bit,
                                        int long_bit, int onoff_bit,
                                        logic [NOW_BITS-1:0] now);
         case (ph)
            BP_IDLE: begin
               if (lv) begin
                  started[idx] = now;
                  return BP_HELD;
               end
            end
            BP_HELD: begin
               if (age(now, idx) > cfg.long_press_ms) begin
                  if (oo_lv && other) begin
                     // Three-button chord wipes everything before latching.
                     clear_everything();
                     flags[EV_ALL_THREE_LONG] = 1'b1;
                  end else if (oo_lv) begin
                     flags[onoff_bit] = 1'b1;
                  end else if (other) begin
                     flags[EV_UPDOWN_LONG] = 1'b1;
                  end else begin
                     flags[long_bit] = 1'b1;
                  end
                  return BP_WAIT_RELEASE;
               end else if (!lv) begin
                  flags[click_bit] = 1'b1;
                  return BP_IDLE;
               end
            end
            BP_WAIT_RELEASE: begin
               if (!lv) return BP_IDLE;
            end
            default: return BP_IDLE;
         endcase
         return ph;
      endfunction

      function void sample_tick(logic oo_lv, logic m_lv, logic up_lv, logic dn_lv,
                                logic [NOW_BITS-1:0] now);
         // After a clear-all nothing happens until every button is let go.
         if (held_after_clear && (oo_lv || m_lv || up_lv || dn_lv)) return;
         held_after_clear = 1'b0;

         case (oo_ph)
            OO_IDLE: begin
               if (oo_lv) begin
                  started[IDX_ONOFF] = now;
                  oo_ph = OO_HELD;
               end
            end
            OO_HELD: begin
               if (age(now, IDX_ONOFF) > cfg.long_press_ms) begin
                  flags[EV_ONOFF_LONG] = 1'b1;
                  oo_ph = OO_WAIT_RELEASE;
               end else if (!oo_lv) begin
                  if (age(now, IDX_ONOFF) <= cfg.quick_release_ms) begin
                     started[IDX_ONOFF] = now;
                     oo_ph = OO_WAIT_SECOND;
                  end else begin
                     flags[EV_ONOFF_CLICK] = 1'b1;
                     oo_ph = OO_IDLE;
                  end
               end
            end
            OO_WAIT_RELEASE: begin
               if (!oo_lv) oo_ph = OO_IDLE;
            end
            OO_WAIT_SECOND: begin
               if (oo_lv) begin
                  started[IDX_ONOFF] = now;
                  oo_ph = OO_SECOND_HOLD;
               end else if (age(now, IDX_ONOFF) > cfg.second_press_wait_ms) begin
                  flags[EV_ONOFF_CLICK] = 1'b1;
                  oo_ph = OO_IDLE;
               end
            end
            OO_SECOND_HOLD: begin
               if (age(now, IDX_ONOFF) > cfg.click_long_ms) begin
                  flags[EV_ONOFF_CLICK_LONG] = 1'b1;
                  oo_ph = OO_WAIT_RELEASE;
               end else if (!oo_lv) begin
                  flags[EV_ONOFF_CLICK] = 1'b1;
                  oo_ph = OO_IDLE;
               end
            end
            default: oo_ph = OO_IDLE;
         endcase

         // Later machines see whatever the earlier ones left behind.
         m_ph  = step_side(m_ph, m_lv, 1'b0, 1'b0, IDX_M, EV_M_CLICK, EV_M_LONG,
                           EV_M_LONG, now);
         up_ph = step_side(up_ph, up_lv, dn_lv, oo_lv, IDX_UP, EV_UP_CLICK,
                           EV_UP_LONG, EV_ONOFF_UP_LONG, now);
         dn_ph = step_side(dn_ph, dn_lv, up_lv, oo_lv, IDX_DOWN, EV_DOWN_CLICK,
                           EV_DOWN_LONG, EV_ONOFF_DOWN_LONG, now);
      endfunction

      function logic [EVENT_BITS-1:0] predict_events(item_type it);
         logic up_lv;
         logic dn_lv;
         up_lv = cfg.swap_up_down ? it.down_level : it.up_level;
         dn_lv = cfg.swap_up_down ? it.up_level : it.down_level;
         case (it.operation)
            OP_TICK:       sample_tick(it.onoff_level, it.m_level, up_lv, dn_lv, it.now_ms);
            OP_CLEAR_MASK: flags &= ~it.clear_mask;
            OP_CLEAR_ALL:  clear_everything();
            default: ;
         endcase
         return flags;
      endfunction

      function void note_beat(item_type it);
         expected_events.push_back(predict_events(it));
      endfunction

      function void check_result(logic [EVENT_BITS-1:0] got);
         logic [EVENT_BITS-1:0] want;
         if (expected_events.size() == 0) begin
            report($sformatf("result beat 0x%04h with nothing outstanding", got));
            return;
         end
         want = expected_events.pop_front();
         if (got !== want) begin
            report($sformatf("pending_events 0x%04h, expected 0x%04h", got, want));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_operation;
   logic                      req_up_level;
   logic                      req_down_level;
   logic                      req_onoff_level;
   logic                      req_m_level;
   logic [NOW_BITS-1:0]       req_now_ms;
   logic [EVENT_BITS-1:0]     req_clear_mask;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [EVENT_BITS-1:0]     rsp_pending_events;
   logic                      csr_write_enable;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_write_data;

   event_scoreboard     sb;
   logic [NOW_BITS-1:0] ms_now;
   int unsigned         beats_sent;
   int unsigned         burst_left;
   bit                  long_hold_due;

   button_click_long_press_detector u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_up_level       (req_up_level),
      .req_down_level     (req_down_level),
      .req_onoff_level    (req_onoff_level),
      .req_m_level        (req_m_level),
      .req_now_ms         (req_now_ms),
      .req_clear_mask     (req_clear_mask),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pending_events (rsp_pending_events),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both channels at the rising edge, where beats are taken.
   always @(posedge clock) begin
      item_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.operation   = req_operation;
            seen.up_level    = req_up_level;
            seen.down_level  = req_down_level;
            seen.onoff_level = req_onoff_level;
            seen.m_level     = req_m_level;
            seen.now_ms      = req_now_ms;
            seen.clear_mask  = req_clear_mask;
            sb.note_beat(seen);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_pending_events);
         end
      end
   end

   // Receiver: stalls follow their own pattern, with one long hold-off
   // when asked so that the block backs up into its request channel.
   initial begin
      rx_mode_type mode;
      int unsigned span_len;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            rsp_stall = 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         mode = rx_mode_type'($urandom_range(0, RX_HEAVY));
         span_len = $urandom_range(10, 60);
         repeat (span_len) begin
            case (mode)
               RX_FREE:  rsp_stall = 1'b0;
               RX_LIGHT: rsp_stall = ($urandom_range(0, 3) == 0);
               RX_HALF:  rsp_stall = 1'($urandom_range(0, 1));
               default:  rsp_stall = ($urandom_range(0, 3) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      #5ms;
      $display("[button_click_long_press_detector] ERROR");
      $finish;
   end

   // Offers one beat and holds it until taken. Bursts of random length are
   // separated by random gaps, and some bursts follow on with no gap.
   task automatic send_beat(input item_type it);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = 0;
         if ($urandom_range(0, 2) != 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
         end
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid       = 1'b1;
      req_operation   = it.operation;
      req_up_level    = it.up_level;
      req_down_level  = it.down_level;
      req_onoff_level = it.onoff_level;
      req_m_level     = it.m_level;
      req_now_ms      = it.now_ms;
      req_clear_mask  = it.clear_mask;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
   endtask

   // Sample tick with the given levels, delta milliseconds after the last.
   task automatic tick_at(input logic [3:0] lv, input int unsigned delta);
      item_type it;
      ms_now = ms_now + delta;
      it.operation   = OP_TICK;
      it.onoff_level = lv[3];
      it.m_level     = lv[2];
      it.up_level    = lv[1];
      it.down_level  = lv[0];
      it.now_ms      = ms_now;
      it.clear_mask  = EVENT_BITS'($urandom);
      send_beat(it);
   endtask

   // Non-tick operation; the levels and time carried with it are noise.
   task automatic send_op(input logic [1:0] op, input logic [EVENT_BITS-1:0] mask);
      item_type it;
      it.operation   = op;
      it.onoff_level = 1'($urandom_range(0, 1));
      it.m_level     = 1'($urandom_range(0, 1));
      it.up_level    = 1'($urandom_range(0, 1));
      it.down_level  = 1'($urandom_range(0, 1));
      it.now_ms      = $urandom;
      it.clear_mask  = mask;
      send_beat(it);
   endtask

   // Press after lead ms, hold for some ticks, release dur ms after the press.
   task automatic press_release(input logic [3:0] lv, input int unsigned lead,
                                input int unsigned dur, input int unsigned held);
      int unsigned step;
      step = dur / (held + 1);
      tick_at(lv, lead);
      repeat (held) tick_at(lv, step);
      tick_at(B_NONE, dur - held * step);
   endtask

   // A duration on, just either side of, or well away from a threshold.
   function automatic int unsigned near_ms(input int unsigned th);
      case ($urandom_range(0, 5))
         0: return th;
         1: return th + 1;
         2: return (th > 0) ? th - 1 : 0;
         3: return $urandom_range(0, th);
         4: return th + $urandom_range(1, 300);
         default: return $urandom_range(0, th + th / 2 + 2);
      endcase
   endfunction

   function automatic logic [3:0] pick_chord();
      case ($urandom_range(0, 4))
         0: return B_UP | B_DOWN;
         1: return B_ONOFF | B_UP;
         2: return B_ONOFF | B_DOWN;
         3: return B_ONOFF | B_UP | B_DOWN;
         default: return 4'($urandom_range(1, 15));
      endcase
   endfunction

   task automatic run_gesture();
      gesture_kind_type kind;
      logic [3:0]  lv;
      int unsigned lp;
      int unsigned qr;
      int unsigned sw;
      int unsigned cl;
      lp = 32'(sb.cfg.long_press_ms);
      qr = 32'(sb.cfg.quick_release_ms);
      sw = 32'(sb.cfg.second_press_wait_ms);
      cl = 32'(sb.cfg.click_long_ms);
      kind = gesture_kind_type'($urandom_range(0, G_JUMP));
      case (kind)
         G_CLICK: begin
            press_release(B_DOWN << $urandom_range(0, 3), $urandom_range(1, 50),
                          near_ms(lp), $urandom_range(0, 3));
         end
         G_LONG: begin
            press_release(B_DOWN << $urandom_range(0, 3), $urandom_range(1, 50),
                          lp + $urandom_range(1, 400), $urandom_range(1, 4));
         end
         G_CLICK_LONG: begin
            // Quick on/off click, optional idle tick, then the second hold.
            press_release(B_ONOFF, $urandom_range(1, 50), near_ms(qr), $urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0) tick_at(B_NONE, near_ms(sw));
            press_release(B_ONOFF, near_ms(sw), near_ms(cl), $urandom_range(0, 3));
            tick_at(B_NONE, near_ms(sw));
         end
         G_CHORD: begin
            lv = pick_chord();
            // Sometimes the buttons of a chord land one tick apart.
            if ($urandom_range(0, 2) == 0) begin
               tick_at(lv & 4'($urandom_range(0, 15)), $urandom_range(1, 40));
            end
            press_release(lv, $urandom_range(0, 40), near_ms(lp) + $urandom_range(0, 100),
                          $urandom_range(0, 3));
         end
         G_NOISE: begin
            repeat ($urandom_range(2, 8)) begin
               tick_at(4'($urandom_range(0, 15)),
                       $urandom_range(0, 1) ? near_ms(lp) : $urandom_range(0, 60));
            end
            tick_at(B_NONE, $urandom_range(0, 60));
         end
         G_CLEAR_ALL: begin
            // Held buttons after a clear-all must be ignored until release.
            send_op(OP_CLEAR_ALL, EVENT_BITS'($urandom));
            repeat ($urandom_range(1, 3)) tick_at(4'($urandom_range(1, 15)), near_ms(lp));
            tick_at(B_NONE, $urandom_range(0, 60));
         end
         default: begin
            // Jump the time base, often to just short of the wrap.
            if ($urandom_range(0, 1)) begin
               ms_now = $urandom;
            end else begin
               ms_now = 32'hFFFF_FFFF - $urandom_range(0, 3 * lp + 10);
            end
            press_release($urandom_range(0, 1) ? pick_chord() : (B_DOWN << $urandom_range(0, 3)),
                          $urandom_range(0, 20), near_ms(lp), $urandom_range(0, 3));
         end
      endcase

      // Flags are sticky, so clear them often to keep new events visible.
      case ($urandom_range(0, 5))
         0, 1: send_op(OP_CLEAR_MASK, EVENT_BITS'($urandom));
         2:    send_op(OP_CLEAR_MASK, '1);
         3:    send_op(OP_UNUSED, EVENT_BITS'($urandom));
         default: ;
      endcase
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned goal;
      goal = beats_sent + count;
      while (beats_sent < goal) run_gesture();
   endtask

   // Wait until every beat has been answered and the block is idle.
   task automatic drain();
      req_valid = 1'b0;
      while (sb.expected_events.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = val;
      @(negedge clock);
      csr_write_enable = 1'b0;
      sb.set_reg(idx, val);
   endtask

   task automatic apply_settings(input logic swap, input logic [15:0] lp,
                                 input logic [15:0] qr, input logic [15:0] sw,
                                 input logic [15:0] cl);
      // Upper bits of the swap write are junk that must be ignored.
      write_reg(CSR_SWAP_UP_DOWN, {15'($urandom_range(0, 16'h7FFF)), swap});
      write_reg(CSR_LONG_PRESS, lp);
      write_reg(CSR_QUICK_RELEASE, qr);
      write_reg(CSR_SECOND_PRESS, sw);
      write_reg(CSR_CLICK_LONG, cl);
   endtask

   // Directed sequence at the reset thresholds (long 500, quick 200,
   // second press 300, click-long 1500), starting just before the wrap.
   task automatic run_directed();
      ms_now = 32'hFFFF_FF00;
      // On/off click across the time wrap, released after the quick window.
      tick_at(B_ONOFF, 0);
      tick_at(B_NONE, 300);
      // M released exactly at the long-press threshold is still a click.
      tick_at(B_M, 10);
      tick_at(B_NONE, 500);
      // Up held one past the threshold.
      tick_at(B_UP, 10);
      tick_at(B_UP, 501);
      tick_at(B_NONE, 10);
      // Up and down together.
      tick_at(B_UP | B_DOWN, 10);
      tick_at(B_UP | B_DOWN, 501);
      tick_at(B_NONE, 10);
      send_op(OP_CLEAR_MASK, '1);
      // On/off with up, then on/off with down.
      tick_at(B_ONOFF | B_UP, 10);
      tick_at(B_ONOFF | B_UP, 600);
      tick_at(B_NONE, 10);
      tick_at(B_ONOFF | B_DOWN, 10);
      tick_at(B_ONOFF | B_DOWN, 600);
      tick_at(B_NONE, 10);
      // All three: everything cleared, then held ticks are ignored.
      tick_at(B_ONOFF | B_UP | B_DOWN, 10);
      tick_at(B_ONOFF | B_UP | B_DOWN, 600);
      tick_at(B_ONOFF | B_UP | B_DOWN, 10);
      tick_at(B_NONE, 10);
      // Release exactly at the quick window, second press, long second hold.
      tick_at(B_ONOFF, 10);
      tick_at(B_NONE, 200);
      tick_at(B_ONOFF, 300);
      tick_at(B_ONOFF, 1501);
      tick_at(B_NONE, 10);
      send_op(OP_UNUSED, '1);
      send_op(OP_CLEAR_ALL, '0);
   endtask

   initial begin
      sb = new();
      ms_now           = '0;
      beats_sent       = 0;
      burst_left       = 0;
      long_hold_due    = 1'b0;
      req_valid        = 1'b0;
      req_operation    = OP_TICK;
      req_up_level     = 1'b0;
      req_down_level   = 1'b0;
      req_onoff_level  = 1'b0;
      req_m_level      = 1'b0;
      req_now_ms       = '0;
      req_clear_mask   = '0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_SWAP_UP_DOWN;
      csr_write_data   = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      run_directed();
      long_hold_due = 1'b1;
      random_phase(220);

      // Smallest thresholds with up and down swapped.
      drain();
      apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
      random_phase(200);

      // Largest thresholds.
      drain();
      apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      random_phase(200);

      // Short random thresholds, then fully random ones.
      drain();
      apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 800)),
                     16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                     16'($urandom_range(0, 2000)));
      random_phase(200);
      drain();
      apply_settings(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom));
      random_phase(200);

      drain();
      if (sb.errors == 0) begin
         $display("[button_click_long_press_detector] OK");
      end else begin
         $display("[button_click_long_press_detector] ERROR");
      end
      $finish;
   end

endmodule
